// ===== hw/rtl/dptf_pkg.sv =====
// Disc player transport controller: shared types, codes and the transition table.
// No dependencies; imported by disc_player_transport_fsm and its testbench.
package dptf_pkg;

    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;
    localparam int unsigned TRACK_W   = 8;
    localparam logic [TRACK_W-1:0] MAX_TRACK_RST = 8'd100;
    localparam logic [TRACK_W-1:0] TRACK_FIRST   = 8'd1;
    localparam logic [TRACK_W-1:0] TRACK_NONE    = 8'd0;

    // config register indexes (paddr[2] selects the 32-bit word)
    localparam logic REG_MAX_TRACK = 1'b0;

    typedef enum logic [3:0] {
        MODE_OFF     = 4'd0,
        MODE_NO_DISC = 4'd1,
        MODE_LOAD    = 4'd2,
        MODE_EJECT   = 4'd3,
        MODE_STOP    = 4'd4,
        MODE_PLAY    = 4'd5,
        MODE_PAUSE   = 4'd6,
        MODE_PREV    = 4'd7,
        MODE_NEXT    = 4'd8
    } mode_t;

    typedef enum logic [3:0] {
        EV_PWR_ON     = 4'd0,
        EV_PWR_OFF    = 4'd1,
        EV_LOAD_EJECT = 4'd2,
        EV_WAIT_DONE  = 4'd3,
        EV_PLAY_PAUSE = 4'd4,
        EV_PREV_PRESS = 4'd5,
        EV_NEXT_PRESS = 4'd6,
        EV_FAST_TICK  = 4'd7,
        EV_RELEASE    = 4'd8
    } event_t;

    typedef enum logic [2:0] {
        DISP_NO_DISC  = 3'd0,
        DISP_STOP     = 3'd1,
        DISP_LOADING  = 3'd2,
        DISP_EJECTING = 3'd3,
        DISP_PLAY     = 3'd4,
        DISP_PAUSE    = 3'd5,
        DISP_PREVIOUS = 3'd6,
        DISP_NEXT     = 3'd7
    } disp_t;

    typedef enum logic {
        ACK_PWR_ON  = 1'b0,
        ACK_PWR_OFF = 1'b1
    } ack_t;

    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_PON,
        ACT_POFF,
        ACT_NODISC,
        ACT_LOAD,
        ACT_EJECT,
        ACT_STOP,
        ACT_EJDONE,
        ACT_PLAY,
        ACT_PAUSE,
        ACT_PREV,
        ACT_NEXT,
        ACT_FPREV,
        ACT_FNEXT,
        ACT_FON,
        ACT_FOFF
    } action_t;

    typedef struct packed {
        logic                power_ack_valid;
        ack_t                power_ack_code;
        logic                display_valid;
        disp_t               display_code;
        logic [TRACK_W-1:0]  display_track;
        logic                wait_timer_start;
        logic                wait_timer_stop;
        logic                fast_timer_start;
        logic                fast_timer_stop;
        mode_t               mode_now;
        logic                disc_flag;
        logic [TRACK_W-1:0]  track_now;
    } result_t;

    // Mode after an event; unknown event codes leave the mode alone.
    function automatic mode_t next_mode_f(input logic [3:0] ev, input mode_t cur);
        mode_t nm;
        nm = cur;
        case (ev)
            EV_PWR_ON:
            begin
                if (cur == MODE_OFF)
                begin
                    nm = MODE_NO_DISC;
                end
            end
            EV_PWR_OFF:
            begin
                nm = MODE_OFF;
            end
            EV_LOAD_EJECT:
            begin
                case (cur) inside
                    MODE_OFF, MODE_LOAD:           nm = cur;
                    MODE_NO_DISC:                  nm = MODE_LOAD;
                    default:                       nm = MODE_EJECT;
                endcase
            end
            EV_WAIT_DONE:
            begin
                case (cur) inside
                    MODE_LOAD:                     nm = MODE_STOP;
                    MODE_EJECT:                    nm = MODE_NO_DISC;
                    default:                       nm = cur;
                endcase
            end
            EV_PLAY_PAUSE:
            begin
                case (cur) inside
                    MODE_STOP, MODE_PAUSE:         nm = MODE_PLAY;
                    MODE_PLAY:                     nm = MODE_PAUSE;
                    default:                       nm = cur;
                endcase
            end
            EV_PREV_PRESS:
            begin
                case (cur) inside
                    MODE_STOP, MODE_PLAY, MODE_PREV, MODE_NEXT: nm = MODE_PREV;
                    default:                                    nm = cur;
                endcase
            end
            EV_NEXT_PRESS:
            begin
                case (cur) inside
                    MODE_STOP, MODE_PLAY, MODE_PREV, MODE_NEXT: nm = MODE_NEXT;
                    default:                                    nm = cur;
                endcase
            end
            EV_RELEASE:
            begin
                case (cur) inside
                    MODE_PREV, MODE_NEXT:          nm = MODE_STOP;
                    default:                       nm = cur;
                endcase
            end
            default:
            begin
                nm = cur;
            end
        endcase
        return nm;
    endfunction

    // Action taken for an event in a given mode.
    function automatic action_t action_f(input logic [3:0] ev, input mode_t cur);
        action_t act;
        act = ACT_NOP;
        case (ev)
            EV_PWR_ON:
            begin
                if (cur == MODE_OFF)
                begin
                    act = ACT_PON;
                end
            end
            EV_PWR_OFF:
            begin
                act = ACT_POFF;
            end
            EV_LOAD_EJECT:
            begin
                case (cur) inside
                    MODE_NO_DISC:                  act = ACT_LOAD;
                    [MODE_STOP:MODE_NEXT]:         act = ACT_EJECT;
                    default:                       act = ACT_NOP;
                endcase
            end
            EV_WAIT_DONE:
            begin
                case (cur) inside
                    MODE_LOAD:                     act = ACT_STOP;
                    MODE_EJECT:                    act = ACT_EJDONE;
                    default:                       act = ACT_NOP;
                endcase
            end
            EV_PLAY_PAUSE:
            begin
                case (cur) inside
                    MODE_NO_DISC:                  act = ACT_NODISC;
                    MODE_STOP, MODE_PAUSE:         act = ACT_PLAY;
                    MODE_PLAY:                     act = ACT_PAUSE;
                    default:                       act = ACT_NOP;
                endcase
            end
            EV_PREV_PRESS:
            begin
                case (cur) inside
                    MODE_NO_DISC:                                act = ACT_NODISC;
                    MODE_PAUSE:                                  act = ACT_FON;
                    MODE_STOP, MODE_PLAY, MODE_PREV, MODE_NEXT:  act = ACT_PREV;
                    default:                                     act = ACT_NOP;
                endcase
            end
            EV_NEXT_PRESS:
            begin
                case (cur) inside
                    MODE_NO_DISC:                                act = ACT_NODISC;
                    MODE_PAUSE:                                  act = ACT_FON;
                    MODE_STOP, MODE_PLAY, MODE_PREV, MODE_NEXT:  act = ACT_NEXT;
                    default:                                     act = ACT_NOP;
                endcase
            end
            EV_FAST_TICK:
            begin
                case (cur) inside
                    MODE_PAUSE, MODE_PREV:         act = ACT_FPREV;
                    MODE_NEXT:                     act = ACT_FNEXT;
                    default:                       act = ACT_NOP;
                endcase
            end
            EV_RELEASE:
            begin
                case (cur) inside
                    [MODE_STOP:MODE_NEXT]:         act = ACT_FOFF;
                    default:                       act = ACT_NOP;
                endcase
            end
            default:
            begin
                act = ACT_NOP;
            end
        endcase
        return act;
    endfunction

endpackage

// ===== hw/rtl/disc_player_transport_fsm.sv =====
// Disc player transport controller top level: event register, table-driven
// transport mode update and result register. Depends on dptf_pkg.
//
// Pipeline: event register, then result register; throughput is one item per
//   cycle while out_stall is low, set by the single table lookup plus track
//   step that sits between the two registers.
// Reset (rst_n low, async): mode off, no disc, track 1, seek backward,
//   max_track 100, both register stages empty.
module disc_player_transport_fsm
(
    input  logic                          clk,
    input  logic                          rst_n,

    // APB-style config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dptf_pkg::PADDR_W-1:0]  paddr,
    input  logic [dptf_pkg::PDATA_W-1:0]  pwdata,
    output logic [dptf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,

    // event item channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [3:0]                    event_req,

    // result item channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          power_ack_valid,
    output logic                          power_ack_code,
    output logic                          display_valid,
    output logic [2:0]                    display_code,
    output logic [dptf_pkg::TRACK_W-1:0]  display_track,
    output logic                          wait_timer_start,
    output logic                          wait_timer_stop,
    output logic                          fast_timer_start,
    output logic                          fast_timer_stop,
    output logic [3:0]                    mode_now,
    output logic                          disc_flag,
    output logic [dptf_pkg::TRACK_W-1:0]  track_now
);
    import dptf_pkg::*;

    // ---------------------------------------------------------------
    // Config register
    // ---------------------------------------------------------------
    logic [TRACK_W-1:0] max_track_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    // Low address bits are byte lanes; paddr[2] picks the register word.
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_TRACK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_track_reg <= MAX_TRACK_RST;
        end
        else if (cfg_wr)
        begin
            max_track_reg <= pwdata[TRACK_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MAX_TRACK)
        begin
            prdata[TRACK_W-1:0] = max_track_reg;
        end
    end

    // ---------------------------------------------------------------
    // Handshake: event register feeds the result register; the event
    // stage moves forward whenever the result register is empty or
    // being drained this cycle.
    // ---------------------------------------------------------------
    logic        ev_valid_reg;
    logic        ev_valid_next;
    logic [3:0]  ev_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        advance;
    logic        in_accept;

    assign advance   = ev_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = ev_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        ev_valid_next = ev_valid_reg;
        if (in_accept)
        begin
            ev_valid_next = 1'b1;
        end
        else if (advance)
        begin
            ev_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ev_valid_reg  <= ev_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // event payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ev_reg <= event_req;
        end
    end

    // ---------------------------------------------------------------
    // Transport state
    // ---------------------------------------------------------------
    mode_t              mode_reg,  mode_next;
    logic               disc_reg,  disc_next;
    logic [TRACK_W-1:0] track_reg, track_next;
    logic               seek_fwd_reg, seek_fwd_next;
    action_t            act;
    result_t            result_reg, result_next;

    // zero max_track behaves as one
    logic [TRACK_W-1:0] top_track;
    logic [TRACK_W-1:0] track_dn;
    logic [TRACK_W-1:0] track_up;

    assign top_track = (max_track_reg == '0) ? TRACK_FIRST : max_track_reg;
    assign track_dn  = (track_reg <= TRACK_FIRST) ? top_track : (track_reg - TRACK_FIRST);
    assign track_up  = (track_reg >= top_track) ? TRACK_FIRST : (track_reg + TRACK_FIRST);

    assign act = action_f(ev_reg, mode_reg);

    // next mode
    always_comb
    begin
        mode_next = next_mode_f(ev_reg, mode_reg);
    end

    // actions and result fields
    always_comb
    begin
        result_next   = '0;
        disc_next     = disc_reg;
        track_next    = track_reg;
        seek_fwd_next = seek_fwd_reg;

        // direction latch runs in any mode
        if (ev_reg == EV_PREV_PRESS)
        begin
            seek_fwd_next = 1'b0;
        end
        else if (ev_reg == EV_NEXT_PRESS)
        begin
            seek_fwd_next = 1'b1;
        end

        case (act)
            ACT_PON:
            begin
                result_next.power_ack_valid = 1'b1;
                result_next.power_ack_code  = ACK_PWR_ON;
                result_next.display_valid   = 1'b1;
                result_next.display_code    = disc_reg ? DISP_STOP : DISP_NO_DISC;
                result_next.display_track   = track_reg;
            end
            ACT_POFF:
            begin
                result_next.power_ack_valid = 1'b1;
                result_next.power_ack_code  = ACK_PWR_OFF;
                result_next.wait_timer_stop = 1'b1;
                result_next.fast_timer_stop = 1'b1;
            end
            ACT_NODISC, ACT_EJDONE:
            begin
                if (act == ACT_EJDONE)
                begin
                    disc_next = 1'b0;
                end
                result_next.display_valid = 1'b1;
                result_next.display_code  = DISP_NO_DISC;
            end
            ACT_LOAD:
            begin
                disc_next = 1'b1;
                result_next.display_valid    = 1'b1;
                result_next.display_code     = DISP_LOADING;
                result_next.wait_timer_start = 1'b1;
            end
            ACT_EJECT:
            begin
                result_next.display_valid    = 1'b1;
                result_next.display_code     = DISP_EJECTING;
                result_next.wait_timer_start = 1'b1;
            end
            ACT_STOP:
            begin
                disc_next = 1'b1;
                result_next.display_valid = 1'b1;
                result_next.display_code  = DISP_STOP;
                result_next.display_track = track_reg;
            end
            ACT_PLAY, ACT_PAUSE:
            begin
                result_next.display_valid = 1'b1;
                if (disc_reg)
                begin
                    result_next.display_code  = (act == ACT_PLAY) ? DISP_PLAY : DISP_PAUSE;
                    result_next.display_track = track_reg;
                end
            end
            ACT_PREV:
            begin
                result_next.display_valid = 1'b1;
                if (disc_reg)
                begin
                    track_next = track_dn;
                    result_next.display_code  = DISP_PREVIOUS;
                    result_next.display_track = track_dn;
                end
            end
            ACT_NEXT:
            begin
                result_next.display_valid = 1'b1;
                if (disc_reg)
                begin
                    track_next = track_up;
                    result_next.display_code  = DISP_NEXT;
                    result_next.display_track = track_up;
                end
            end
            ACT_FPREV:
            begin
                if (disc_reg)
                begin
                    if (!seek_fwd_reg)
                    begin
                        track_next = track_dn;
                    end
                    result_next.display_valid = 1'b1;
                    result_next.display_code  = DISP_PREVIOUS;
                    result_next.display_track = track_next;
                end
            end
            ACT_FNEXT:
            begin
                if (disc_reg)
                begin
                    if (seek_fwd_reg)
                    begin
                        track_next = track_up;
                    end
                    result_next.display_valid = 1'b1;
                    result_next.display_code  = DISP_NEXT;
                    result_next.display_track = track_next;
                end
            end
            ACT_FON:
            begin
                result_next.fast_timer_start = 1'b1;
            end
            ACT_FOFF:
            begin
                result_next.fast_timer_stop = 1'b1;
            end
            default:
            begin
            end
        endcase

        result_next.mode_now  = mode_next;
        result_next.disc_flag = disc_next;
        result_next.track_now = track_next;
    end

    // state moves only when an item leaves the event stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_OFF;
            disc_reg     <= 1'b0;
            track_reg    <= TRACK_FIRST;
            seek_fwd_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            disc_reg     <= disc_next;
            track_reg    <= track_next;
            seek_fwd_reg <= seek_fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // ---------------------------------------------------------------
    // Output ports
    // ---------------------------------------------------------------
    assign out_valid        = out_valid_reg;
    assign power_ack_valid  = result_reg.power_ack_valid;
    assign power_ack_code   = result_reg.power_ack_code;
    assign display_valid    = result_reg.display_valid;
    assign display_code     = result_reg.display_code;
    assign display_track    = result_reg.display_track;
    assign wait_timer_start = result_reg.wait_timer_start;
    assign wait_timer_stop  = result_reg.wait_timer_stop;
    assign fast_timer_start = result_reg.fast_timer_start;
    assign fast_timer_stop  = result_reg.fast_timer_stop;
    assign mode_now         = result_reg.mode_now;
    assign disc_flag        = result_reg.disc_flag;
    assign track_now        = result_reg.track_now;

endmodule

// ===== sim/disc_player_transport_fsm_tb.sv =====
// Testbench for disc_player_transport_fsm: directed, track-wrap, backpressure and
// random event tests, checked against an in-bench transport predictor.
// Depends on dptf_pkg and the disc_player_transport_fsm RTL.
module disc_player_transport_fsm_tb;
    import dptf_pkg::*;

    // The run ends as a failure past this many cycles, well above the slowest
    // legal run: ~1600 items, each with possible sender idling and receiver
    // stalls, plus one long hold.
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS = 210;

    // Event codes with no meaning to the block.
    localparam logic [3:0] EV_IGNORED_LO = 4'd9;
    localparam logic [3:0] EV_IGNORED_HI = 4'd15;

    // Register 0 sits at byte 0. Byte 4 decodes to an unused index.
    localparam logic [PADDR_W-1:0] ADDR_MAX_TRACK = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_UNUSED    = 3'd4;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [PDATA_W-1:0]   pwdata    = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [3:0]           event_req = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 power_ack_valid;
    logic                 power_ack_code;
    logic                 display_valid;
    logic [2:0]           display_code;
    logic [TRACK_W-1:0]   display_track;
    logic                 wait_timer_start;
    logic                 wait_timer_stop;
    logic                 fast_timer_start;
    logic                 fast_timer_stop;
    logic [3:0]           mode_now;
    logic                 disc_flag;
    logic [TRACK_W-1:0]   track_now;

    // Predictor state. It follows the block one accepted item at a time.
    mode_t                cur_mode    = MODE_OFF;
    logic                 disc_loaded = 1'b0;
    logic [TRACK_W-1:0]   cur_track   = TRACK_FIRST;
    logic                 dir_fwd     = 1'b0;
    logic [TRACK_W-1:0]   track_limit = MAX_TRACK_RST;

    result_t              pending_results[$];

    int                   events_sent      = 0;
    int                   ignored_sent     = 0;
    int                   results_seen     = 0;
    int                   mismatches       = 0;
    int                   settings_written = 0;
    int                   cycle_count      = 0;

    // Idle controls. The long receiver hold is counted in the stall process.
    bit                   sender_idle_on = 1'b1;
    bit                   stall_idle_on  = 1'b1;
    bit                   hold_req       = 1'b0;
    int                   hold_left      = 0;
    int                   stall_left     = 0;

    disc_player_transport_fsm u_top
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .event_req        (event_req),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .power_ack_valid  (power_ack_valid),
        .power_ack_code   (power_ack_code),
        .display_valid    (display_valid),
        .display_code     (display_code),
        .display_track    (display_track),
        .wait_timer_start (wait_timer_start),
        .wait_timer_stop  (wait_timer_stop),
        .fast_timer_start (fast_timer_start),
        .fast_timer_stop  (fast_timer_stop),
        .mode_now         (mode_now),
        .disc_flag        (disc_flag),
        .track_now        (track_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Predicts one event item. Updates mode, disc flag, track and seek direction,
    // and returns the result the block should produce for it.
    function automatic result_t step_transport(input logic [3:0] ev);
        result_t            r;
        logic [TRACK_W-1:0] top;
        mode_t              m;
        r   = '0;
        top = (track_limit == TRACK_NONE) ? TRACK_FIRST : track_limit;
        m   = cur_mode;
        // Direction latch: set by any prev/next press, even when powered off.
        if (ev == EV_PREV_PRESS)
        begin
            dir_fwd = 1'b0;
        end
        if (ev == EV_NEXT_PRESS)
        begin
            dir_fwd = 1'b1;
        end
        case (ev)
            EV_PWR_ON:
            begin
                if (m == MODE_OFF)
                begin
                    r.power_ack_valid = 1'b1;
                    r.power_ack_code  = ACK_PWR_ON;
                    r.display_valid   = 1'b1;
                    if (disc_loaded)
                    begin
                        r.display_code = DISP_STOP;
                    end
                    else
                    begin
                        r.display_code = DISP_NO_DISC;
                    end
                    // Power-on message carries the track in both flavors.
                    r.display_track = cur_track;
                    cur_mode        = MODE_NO_DISC;
                end
            end
            EV_PWR_OFF:
            begin
                r.power_ack_valid = 1'b1;
                r.power_ack_code  = ACK_PWR_OFF;
                r.wait_timer_stop = 1'b1;
                r.fast_timer_stop = 1'b1;
                cur_mode          = MODE_OFF;
            end
            EV_LOAD_EJECT:
            begin
                if (m == MODE_NO_DISC)
                begin
                    disc_loaded        = 1'b1;
                    r.display_valid    = 1'b1;
                    r.display_code     = DISP_LOADING;
                    r.wait_timer_start = 1'b1;
                    cur_mode           = MODE_LOAD;
                end
                else if (m >= MODE_STOP)
                begin
                    r.display_valid    = 1'b1;
                    r.display_code     = DISP_EJECTING;
                    r.wait_timer_start = 1'b1;
                    cur_mode           = MODE_EJECT;
                end
            end
            EV_WAIT_DONE:
            begin
                if (m == MODE_LOAD)
                begin
                    disc_loaded     = 1'b1;
                    r.display_valid = 1'b1;
                    r.display_code  = DISP_STOP;
                    r.display_track = cur_track;
                    cur_mode        = MODE_STOP;
                end
                else if (m == MODE_EJECT)
                begin
                    disc_loaded     = 1'b0;
                    r.display_valid = 1'b1;
                    r.display_code  = DISP_NO_DISC;
                    cur_mode        = MODE_NO_DISC;
                end
            end
            EV_PLAY_PAUSE:
            begin
                if (m == MODE_NO_DISC)
                begin
                    r.display_valid = 1'b1;
                    r.display_code  = DISP_NO_DISC;
                end
                else if (m == MODE_STOP || m == MODE_PLAY || m == MODE_PAUSE)
                begin
                    r.display_valid = 1'b1;
                    if (disc_loaded)
                    begin
                        if (m == MODE_PLAY)
                        begin
                            r.display_code = DISP_PAUSE;
                        end
                        else
                        begin
                            r.display_code = DISP_PLAY;
                        end
                        r.display_track = cur_track;
                    end
                    if (m == MODE_PLAY)
                    begin
                        cur_mode = MODE_PAUSE;
                    end
                    else
                    begin
                        cur_mode = MODE_PLAY;
                    end
                end
            end
            EV_PREV_PRESS, EV_NEXT_PRESS:
            begin
                if (m == MODE_NO_DISC)
                begin
                    r.display_valid = 1'b1;
                    r.display_code  = DISP_NO_DISC;
                end
                else if (m == MODE_PAUSE)
                begin
                    // Holding prev/next while paused starts the fast seek.
                    r.fast_timer_start = 1'b1;
                end
                else if (m >= MODE_STOP)
                begin
                    r.display_valid = 1'b1;
                    if (ev == EV_PREV_PRESS)
                    begin
                        if (disc_loaded)
                        begin
                            cur_track       = (cur_track <= TRACK_FIRST) ? top : cur_track - 1'b1;
                            r.display_code  = DISP_PREVIOUS;
                            r.display_track = cur_track;
                        end
                        cur_mode = MODE_PREV;
                    end
                    else
                    begin
                        if (disc_loaded)
                        begin
                            cur_track       = (cur_track >= top) ? TRACK_FIRST : cur_track + 1'b1;
                            r.display_code  = DISP_NEXT;
                            r.display_track = cur_track;
                        end
                        cur_mode = MODE_NEXT;
                    end
                end
            end
            EV_FAST_TICK:
            begin
                // A tick steps the track only when it agrees with the latched direction.
                if (disc_loaded && (m == MODE_PAUSE || m == MODE_PREV))
                begin
                    if (!dir_fwd)
                    begin
                        cur_track = (cur_track <= TRACK_FIRST) ? top : cur_track - 1'b1;
                    end
                    r.display_valid = 1'b1;
                    r.display_code  = DISP_PREVIOUS;
                    r.display_track = cur_track;
                end
                else if (disc_loaded && m == MODE_NEXT)
                begin
                    if (dir_fwd)
                    begin
                        cur_track = (cur_track >= top) ? TRACK_FIRST : cur_track + 1'b1;
                    end
                    r.display_valid = 1'b1;
                    r.display_code  = DISP_NEXT;
                    r.display_track = cur_track;
                end
            end
            EV_RELEASE:
            begin
                if (m >= MODE_STOP)
                begin
                    r.fast_timer_stop = 1'b1;
                end
                if (m == MODE_PREV || m == MODE_NEXT)
                begin
                    cur_mode = MODE_STOP;
                end
            end
            default:
            begin
            end
        endcase
        r.mode_now  = cur_mode;
        r.disc_flag = disc_loaded;
        r.track_now = cur_track;
        return r;
    endfunction

    // Picks the next event from the current mode. Mostly the events that move
    // the player along a normal session; some raw codes and power-offs mixed in.
    function automatic logic [3:0] pick_event();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            return 4'($urandom_range(0, 15));
        end
        if (roll < 10)
        begin
            return EV_PWR_OFF;
        end
        roll = $urandom_range(0, 99);
        case (cur_mode)
            MODE_OFF:
            begin
                if (roll < 70)
                begin
                    return EV_PWR_ON;
                end
            end
            MODE_NO_DISC:
            begin
                if (roll < 50)
                begin
                    return EV_LOAD_EJECT;
                end
            end
            MODE_LOAD, MODE_EJECT:
            begin
                if (roll < 60)
                begin
                    return EV_WAIT_DONE;
                end
            end
            default:
            begin
                if (roll < 5)
                begin
                    return EV_LOAD_EJECT;
                end
                if (roll < 20)
                begin
                    return EV_PLAY_PAUSE;
                end
                if (roll < 40)
                begin
                    return EV_PREV_PRESS;
                end
                if (roll < 60)
                begin
                    return EV_NEXT_PRESS;
                end
                if (roll < 85)
                begin
                    return EV_FAST_TICK;
                end
                return EV_RELEASE;
            end
        endcase
        return 4'($urandom_range(EV_LOAD_EJECT, EV_RELEASE));
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Offers one event item and returns at the edge where it is accepted.
    // Called at a rising edge. valid stays high afterwards so the next item can
    // follow back to back.
    task automatic send_event(input logic [3:0] ev);
        if (sender_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        event_req <= ev;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(step_transport(ev));
        if (ev > EV_RELEASE)
        begin
            ignored_sent++;
        end
        else
        begin
            events_sent++;
        end
    endtask

    // Stops offering items and waits for every pending result, then waits on
    // to cover the two register stages.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    // APB write (setup, then access) once the block is idle, followed by a
    // readback of max_track. Upper data bits are random noise.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [7:0] value);
        logic [PDATA_W-1:0] word;
        drain();
        word      = $urandom;
        word[7:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // write lands at this edge
        if (addr[2] == REG_MAX_TRACK)
        begin
            track_limit = value;
        end
        settings_written++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MAX_TRACK;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        check_field("max_track readback", track_limit, prdata[7:0]);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Walks every event through a session from power-off: ignored
    // codes, presses with no disc, load, play/pause, fast seek both ways, eject.
    task automatic test_directed();
        logic [3:0] steps [0:25];
        steps = '{EV_IGNORED_HI, EV_PREV_PRESS, EV_PLAY_PAUSE, EV_PWR_ON, EV_PWR_ON,
                  EV_PLAY_PAUSE, EV_NEXT_PRESS, EV_FAST_TICK, EV_WAIT_DONE,
                  EV_LOAD_EJECT, EV_LOAD_EJECT, EV_WAIT_DONE, EV_PLAY_PAUSE,
                  EV_PLAY_PAUSE, EV_PREV_PRESS, EV_FAST_TICK, EV_NEXT_PRESS,
                  EV_FAST_TICK, EV_PLAY_PAUSE, EV_NEXT_PRESS, EV_FAST_TICK,
                  EV_RELEASE, EV_IGNORED_LO, EV_LOAD_EJECT, EV_WAIT_DONE, EV_PWR_OFF};
        foreach (steps[i])
        begin
            send_event(steps[i]);
        end
    endtask

    // Track wrap at the limits: 255, lowering the limit below the current
    // track, a write to an unused address, zero (acts as one) and one.
    task automatic test_track_wrap();
        write_reg(ADDR_MAX_TRACK, 8'd255);
        send_event(EV_PWR_ON);
        send_event(EV_LOAD_EJECT);
        send_event(EV_WAIT_DONE);
        send_event(EV_PREV_PRESS);
        send_event(EV_NEXT_PRESS);
        send_event(EV_PREV_PRESS);
        // track 255 above a limit of 5: next wraps to 1, prev goes to 5
        write_reg(ADDR_MAX_TRACK, 8'd5);
        send_event(EV_NEXT_PRESS);
        send_event(EV_PREV_PRESS);
        // track 5 above a limit of 3: prev just counts down
        write_reg(ADDR_MAX_TRACK, 8'd3);
        send_event(EV_PREV_PRESS);
        send_event(EV_NEXT_PRESS);
        write_reg(ADDR_UNUSED, 8'hA5);
        write_reg(ADDR_MAX_TRACK, 8'd0);
        send_event(EV_NEXT_PRESS);
        send_event(EV_PREV_PRESS);
        send_event(EV_FAST_TICK);
        send_event(EV_RELEASE);
        write_reg(ADDR_MAX_TRACK, 8'd1);
        send_event(EV_NEXT_PRESS);
        send_event(EV_FAST_TICK);
        send_event(EV_RELEASE);
        // power cycle with a disc in: power-on shows stop with the track
        send_event(EV_PWR_OFF);
        send_event(EV_PWR_ON);
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the block fills and stalls its input.
    task automatic test_backpressure();
        write_reg(ADDR_MAX_TRACK, MAX_TRACK_RST);
        sender_idle_on = 1'b0;
        hold_req       = 1'b1;
        repeat (40) send_event(pick_event());
        drain();
        sender_idle_on = 1'b1;
    endtask

    // Random sessions under several limits, extremes among them. Some phases
    // run without idling and the last phase has none on either side.
    task automatic test_random();
        logic [7:0] limits [0:6];
        logic [3:0] ev;
        int         n;
        limits    = '{MAX_TRACK_RST, 8'd255, 8'd0, 8'd1, 8'd2, 8'd13, 8'd0};
        limits[6] = 8'($urandom_range(1, 255));
        for (int p = 0; p < 7; p++)
        begin
            write_reg(ADDR_MAX_TRACK, limits[p]);
            sender_idle_on = (p % 3 != 1) && (p != 6);
            stall_idle_on  = sender_idle_on;
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                ev = pick_event();
                send_event(ev);
                if (ev <= EV_RELEASE)
                begin
                    n++;
                end
            end
        end
    endtask

    // Receiver stall: long hold on request, otherwise random bursts.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (stall_idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 18);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Each accepted result item against the oldest prediction, field by field.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result item: expected none, got mode_now %0d",
                         $time, mode_now);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("power_ack_valid", want.power_ack_valid, power_ack_valid);
                check_field("power_ack_code", want.power_ack_code, power_ack_code);
                check_field("display_valid", want.display_valid, display_valid);
                check_field("display_code", want.display_code, display_code);
                check_field("display_track", want.display_track, display_track);
                check_field("wait_timer_start", want.wait_timer_start, wait_timer_start);
                check_field("wait_timer_stop", want.wait_timer_stop, wait_timer_stop);
                check_field("fast_timer_start", want.fast_timer_start, fast_timer_start);
                check_field("fast_timer_stop", want.fast_timer_stop, fast_timer_stop);
                check_field("mode_now", want.mode_now, mode_now);
                check_field("disc_flag", want.disc_flag, disc_flag);
                check_field("track_now", want.track_now, track_now);
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d results pending", $time, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_track_wrap();
        test_backpressure();
        test_random();
        drain();
        $display("covered %0d events and %0d ignored codes, %0d result items checked",
                 events_sent, ignored_sent, results_seen);
        $display("%0d register writes (limits 0, 1, 255 and others), one long output hold",
                 settings_written);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
